### rtl/ppbp_pkg.sv
package ppbp_pkg;

  // region limits
  localparam int MAX_COLUMNS   = 128;
  localparam int MAX_PAGES     = 8;
  localparam int ROWS_PER_PAGE = 8;

  // internal widths
  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int ROW_W  = $clog2(ROWS_PER_PAGE);
  localparam int PART_W = ROWS_PER_PAGE - 1;

  // compare widths, wide enough for both the register field and the limit
  localparam int COLS_CMP_W  = 9;
  localparam int PAGES_CMP_W = 5;

  // field widths
  localparam int PIXEL_W     = 8;
  localparam int BYTE_W      = 8;
  localparam int PAGE_IDX_W  = 3;
  localparam int COL_IDX_W   = 7;
  localparam int COLS_REG_W  = 8;
  localparam int PAGES_REG_W = 4;
  localparam int THR_REG_W   = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_DATA_W  = 24;

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS_PER_PAGE - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMN_COUNT = 2'd0,
    CFG_PAGE_COUNT   = 2'd1,
    CFG_THRESHOLD    = 2'd2
  } cfg_idx_t;

  // one accepted pixel, tagged with its raster position
  typedef struct packed {
    logic              lit;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [PAGE_W-1:0] page;
    logic              last_row;
    logic              frame_end;
  } item_t;

  typedef struct packed {
    logic valid;
    logic emit;
  } stage_t;

  typedef struct packed {
    logic [BYTE_W-1:0]     page_byte;
    logic [PAGE_IDX_W-1:0] page_index;
    logic [COL_IDX_W-1:0]  column_index;
    logic                  frame_end;
  } result_t;

endpackage

### rtl/ppbp_raster.sv
module ppbp_raster (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ppbp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ppbp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [ppbp_pkg::PIXEL_W-1:0]      pixel,
  input  logic                              advance,
  output ppbp_pkg::item_t                   item
);

  logic [ppbp_pkg::COLS_REG_W-1:0]  column_count_r;
  logic [ppbp_pkg::PAGES_REG_W-1:0] page_count_r;
  logic [ppbp_pkg::THR_REG_W-1:0]   threshold_r;

  logic [ppbp_pkg::COL_W-1:0]  col_r;
  logic [ppbp_pkg::ROW_W-1:0]  row_r;
  logic [ppbp_pkg::PAGE_W-1:0] page_r;

  logic [ppbp_pkg::COL_W-1:0]  col_nxt;
  logic [ppbp_pkg::ROW_W-1:0]  row_nxt;
  logic [ppbp_pkg::PAGE_W-1:0] page_nxt;

  logic [ppbp_pkg::COLS_CMP_W-1:0]  cols_ext;
  logic [ppbp_pkg::COLS_CMP_W-1:0]  cols_act;
  logic [ppbp_pkg::PAGES_CMP_W-1:0] pages_ext;
  logic [ppbp_pkg::PAGES_CMP_W-1:0] pages_act;
  logic last_col;
  logic last_row;
  logic last_page;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= ppbp_pkg::COLS_REG_W'(128);
      page_count_r   <= ppbp_pkg::PAGES_REG_W'(8);
      threshold_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ppbp_pkg::CFG_COLUMN_COUNT: column_count_r <= cfg_wdata[ppbp_pkg::COLS_REG_W-1:0];
        ppbp_pkg::CFG_PAGE_COUNT:   page_count_r   <= cfg_wdata[ppbp_pkg::PAGES_REG_W-1:0];
        ppbp_pkg::CFG_THRESHOLD:    threshold_r    <= cfg_wdata[ppbp_pkg::THR_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // zero counts act as one, oversize counts clamp to the limit
  always_comb begin
    cols_ext  = ppbp_pkg::COLS_CMP_W'(column_count_r);
    pages_ext = ppbp_pkg::PAGES_CMP_W'(page_count_r);
    if (cols_ext == '0)
      cols_act = ppbp_pkg::COLS_CMP_W'(1);
    else if (cols_ext > ppbp_pkg::COLS_CMP_W'(ppbp_pkg::MAX_COLUMNS))
      cols_act = ppbp_pkg::COLS_CMP_W'(ppbp_pkg::MAX_COLUMNS);
    else
      cols_act = cols_ext;
    if (pages_ext == '0)
      pages_act = ppbp_pkg::PAGES_CMP_W'(1);
    else if (pages_ext > ppbp_pkg::PAGES_CMP_W'(ppbp_pkg::MAX_PAGES))
      pages_act = ppbp_pkg::PAGES_CMP_W'(ppbp_pkg::MAX_PAGES);
    else
      pages_act = pages_ext;
  end

  assign last_col  = ppbp_pkg::COLS_CMP_W'(col_r) >= (cols_act - ppbp_pkg::COLS_CMP_W'(1));
  assign last_row  = (row_r == ppbp_pkg::LAST_ROW);
  assign last_page = ppbp_pkg::PAGES_CMP_W'(page_r) >= (pages_act - ppbp_pkg::PAGES_CMP_W'(1));

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    page_nxt = page_r;
    if (!last_col) begin
      col_nxt = col_r + ppbp_pkg::COL_W'(1);
    end else begin
      col_nxt = '0;
      if (!last_row) begin
        row_nxt = row_r + ppbp_pkg::ROW_W'(1);
      end else begin
        row_nxt  = '0;
        page_nxt = last_page ? '0 : page_r + ppbp_pkg::PAGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      page_r <= '0;
    end else if (advance) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      page_r <= page_nxt;
    end
  end

  always_comb begin
    item.lit       = (pixel > threshold_r);
    item.col       = col_r;
    item.row       = row_r;
    item.page      = page_r;
    item.last_row  = last_row;
    item.frame_end = last_col & last_page;
  end

endmodule

### rtl/ppbp_pack.sv
module ppbp_pack (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  ppbp_pkg::item_t   item,
  input  logic              done,
  output ppbp_pkg::stage_t  stage,
  output ppbp_pkg::result_t result
);

  logic [ppbp_pkg::PART_W-1:0] part_mem [ppbp_pkg::MAX_COLUMNS];

  ppbp_pkg::item_t             item_r;
  logic                        valid_r;
  logic [ppbp_pkg::PART_W-1:0] rd_r;
  logic                        fwd_r;
  logic [ppbp_pkg::PART_W-1:0] fwd_data_r;

  logic [ppbp_pkg::PART_W-1:0] old_bits;
  logic [ppbp_pkg::PART_W-1:0] wr_data;
  logic                        wr_en;

  // a write retiring in the same cycle as the read of the same column is forwarded
  assign old_bits = fwd_r ? fwd_data_r : rd_r;
  assign wr_en    = done & ~item_r.last_row;

  always_comb begin
    if (item_r.row == '0)
      wr_data = ppbp_pkg::PART_W'(item_r.lit);
    else
      wr_data = old_bits | (ppbp_pkg::PART_W'(item_r.lit) << item_r.row);
  end

  always_ff @(posedge clk) begin
    if (wr_en)
      part_mem[item_r.col] <= wr_data;
    if (accept)
      rd_r <= part_mem[item.col];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r     <= item;
      fwd_r      <= wr_en && (item_r.col == item.col);
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      valid_r <= 1'b0;
    else if (accept)
      valid_r <= 1'b1;
    else if (done)
      valid_r <= 1'b0;
  end

  assign stage.valid = valid_r;
  assign stage.emit  = item_r.last_row;

  always_comb begin
    result.page_byte    = {item_r.lit, old_bits};
    result.page_index   = ppbp_pkg::PAGE_IDX_W'(item_r.page);
    result.column_index = ppbp_pkg::COL_IDX_W'(item_r.col);
    result.frame_end    = item_r.frame_end;
  end

endmodule

### rtl/pixel_to_page_byte_packer.sv
// path: an eighth-row pixel goes through the pack stage register and the output register to out_tdata
// throughput: one pixel per cycle unless the output is full and stalled, set by the single
// column store read-modify-write (read at accept, write when the pack stage retires, forwarded between)
// reset: synchronous active-low rst_n clears counters and handshake state, loads
// column_count 128, page_count 8, threshold 0; the column store is not cleared
module pixel_to_page_byte_packer (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [ppbp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ppbp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // pixel stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ppbp_pkg::PIXEL_W-1:0]        in_tdata,   // [7:0] pixel
  // page byte stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ppbp_pkg::OUT_DATA_W-1:0]     out_tdata,  // [7:0] page_byte, [10:8] page_index,
                                                          // [17:11] column_index, [23:18] zero
  output logic                                out_tlast   // frame_end
);

  ppbp_pkg::item_t   item;
  ppbp_pkg::stage_t  stage;
  ppbp_pkg::result_t result;

  logic              in_xfer;
  logic              done;
  logic              out_valid_r;
  ppbp_pkg::result_t out_r;

  // the pack stage retires when it has nothing to send or the output register frees up
  assign done      = stage.valid & (~stage.emit | ~out_valid_r | out_tready);
  assign in_tready = ~stage.valid | done;
  assign in_xfer   = in_tvalid & in_tready;

  // config registers, raster counters and threshold compare
  ppbp_raster u_raster (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pixel     (in_tdata),
    .advance   (in_xfer),
    .item      (item)
  );

  // column store read-modify-write and byte assembly
  ppbp_pack u_pack (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_xfer),
    .item   (item),
    .done   (done),
    .stage  (stage),
    .result (result)
  );

  // output register, keeps the pixel side moving while a byte waits
  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (done && stage.emit)
      out_valid_r <= 1'b1;
    else if (out_tready)
      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (done && stage.emit)
      out_r <= result;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_r.column_index, out_r.page_index, out_r.page_byte};
  assign out_tlast  = out_r.frame_end;

`ifndef SYNTHESIS
  // a pixel outside the eighth row never holds up the pack stage
  a_no_emit_retires: assert property (@(posedge clk) disable iff (!rst_n)
    stage.valid && !stage.emit |-> done)
    else $error("non-emitting item stalled in pack stage");

  // every transfer lands in the pack stage
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> stage.valid)
    else $error("accepted pixel lost");

  // a byte appears only when an eighth-row item retires
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(done && stage.emit))
    else $error("output valid without a retiring page byte");

  // a waiting emitting item blocks new pixels only while the output is full and stalled
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (stage.valid && stage.emit && out_valid_r && !out_tready))
    else $error("input stalled without cause");
`endif

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ppbp_pkg::*;

  // idling on both sides and receiver stall length, watchdog limit
  localparam int IDLE_PCT    = 12;
  localparam int LONG_HOLD   = 300;
  localparam int STUCK_LIMIT = 4000;
  localparam int SETTLE      = 6;   // page byte goes through the pack stage and output registers

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [PIXEL_W-1:0]    in_tdata = '0;   // [7:0] pixel

  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [7:0] page_byte, [10:8] page_index,
                                          // [17:11] column_index, [23:18] zero
  logic                  out_tlast;       // frame_end

  pixel_to_page_byte_packer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // packing predictor: its own copy of the registers, counters and column store
  // ---------------------------------------------------------------------------
  logic [COLS_REG_W-1:0]  cols_reg  = 8'd128;
  logic [PAGES_REG_W-1:0] pages_reg = 4'd8;
  logic [THR_REG_W-1:0]   thr_reg   = 8'd0;

  logic [COL_IDX_W-1:0]  col_ctr  = '0;
  logic [2:0]            row_ctr  = '0;
  logic [PAGE_IDX_W-1:0] page_ctr = '0;
  logic [PART_W-1:0]     column_bits [MAX_COLUMNS];
  bit                    column_seen [MAX_COLUMNS];  // column got its row-0 write

  logic [PIXEL_W-1:0] pixel_q[$];      // pixels waiting to be offered
  result_t            page_byte_q[$];  // page bytes the block still owes us

  bit no_idle = 1'b0;  // turns off random idling on both sides
  int mismatches = 0;

  // zero means one column, anything above the store size saturates
  function automatic int unsigned active_cols(input logic [COLS_REG_W-1:0] c);
    if (c == 0) return 1;
    if (c > MAX_COLUMNS) return MAX_COLUMNS;
    return c;
  endfunction

  function automatic int unsigned active_pages(input logic [PAGES_REG_W-1:0] p);
    if (p == 0) return 1;
    if (p > MAX_PAGES) return MAX_PAGES;
    return p;
  endfunction

  // advance the predictor by one accepted pixel, queue the page byte it finishes
  task automatic pack_pixel(input logic [PIXEL_W-1:0] pix);
    int unsigned ncols;
    int unsigned npages;
    logic        lit;
    logic        last_col;
    logic        last_row;
    logic        last_page;
    result_t     done;
    ncols     = active_cols(cols_reg);
    npages    = active_pages(pages_reg);
    lit       = pix > thr_reg;
    last_col  = col_ctr >= ncols - 1;
    last_row  = row_ctr == ROWS_PER_PAGE - 1;
    last_page = page_ctr >= npages - 1;
    if (row_ctr == 0) begin
      column_bits[col_ctr] = PART_W'(lit);
      column_seen[col_ctr] = 1'b1;
    end else if (!last_row) begin
      column_bits[col_ctr] = column_bits[col_ctr] | (PART_W'(lit) << row_ctr);
    end else begin
      done.page_byte    = {lit, column_bits[col_ctr]};
      done.page_index   = page_ctr;
      done.column_index = col_ctr;
      done.frame_end    = last_col && last_page;
      page_byte_q.push_back(done);
    end
    // raster walk: column, then row within the page, then page
    if (!last_col) begin
      col_ctr = col_ctr + 1'b1;
    end else begin
      col_ctr = '0;
      if (!last_row) begin
        row_ctr = row_ctr + 1'b1;
      end else begin
        row_ctr  = '0;
        page_ctr = last_page ? '0 : page_ctr + 1'b1;
      end
    end
  endtask

  // pixels still needed to close the page in progress
  function automatic int unsigned pixels_left_in_page();
    int unsigned ncols;
    int unsigned rest;
    ncols = active_cols(cols_reg);
    if (row_ctr == 0 && col_ctr == 0) return 0;
    rest = (col_ctr >= ncols - 1) ? 1 : ncols - col_ctr;
    return rest + (ROWS_PER_PAGE - 1 - row_ctr) * ncols;
  endfunction

  // ---------------------------------------------------------------------------
  // pixel driver: offers queued pixels, predicts on every transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) pack_pixel(in_tdata);
      // a held pixel stays put until it is taken
      if (!in_tvalid || in_tready) begin
        if (pixel_q.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pixel_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // page byte monitor: checks every transfer, throttles out_tready
  // ---------------------------------------------------------------------------
  int  hold_left = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.page_byte    = out_tdata[7:0];
        got.page_index   = out_tdata[10:8];
        got.column_index = out_tdata[17:11];
        got.frame_end    = out_tlast;
        if (page_byte_q.size() == 0) begin
          $display("%0t: unexpected page byte %h page %0d column %0d frame_end %b",
                   $time, got.page_byte, got.page_index, got.column_index, got.frame_end);
          mismatches++;
        end else begin
          want = page_byte_q.pop_front();
          if (got !== want || out_tdata[OUT_DATA_W-1:18] !== '0) begin
            $display("%0t: mismatch: expected byte %h page %0d column %0d frame_end %b",
                     $time, want.page_byte, want.page_index, want.column_index,
                     want.frame_end);
            $display("%0t:           actual   byte %h page %0d column %0d frame_end %b pad %h",
                     $time, got.page_byte, got.page_index, got.column_index,
                     got.frame_end, out_tdata[OUT_DATA_W-1:18]);
            mismatches++;
          end
        end
      end
      // one long hold-off while plenty of pixels are still queued, so the block
      // backs up and has to drop in_tready
      if (!long_hold_done && out_tvalid && pixel_q.size() > 64) begin
        hold_left      = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      out_tready <= (hold_left == 0) && (no_idle || $urandom_range(99) >= IDLE_PCT);
      if (hold_left != 0) hold_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any transfer means the block is stuck
  // ---------------------------------------------------------------------------
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // sender stops until every pixel is taken and every page byte has come back;
  // checked again after settling, since the last pop and its transfer can land late
  task automatic drain();
    do begin
      while (!(pixel_q.size() == 0 && !in_tvalid && page_byte_q.size() == 0))
        @(posedge clk);
      repeat (SETTLE) @(posedge clk);
    end while (!(pixel_q.size() == 0 && !in_tvalid && page_byte_q.size() == 0));
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_COLUMN_COUNT: cols_reg  = val[COLS_REG_W-1:0];
      CFG_PAGE_COUNT:   pages_reg = val[PAGES_REG_W-1:0];
      CFG_THRESHOLD:    thr_reg   = val[THR_REG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) pixel_q.push_back(PIXEL_W'($urandom_range(255)));
  endtask

  // new region settings while the block is idle; the frame in progress may be
  // left mid-way, except that widening mid-page must not reach columns that
  // never had their row-0 write, so such a change closes the page first
  task automatic program_region(input logic [COLS_REG_W-1:0] c,
                                input logic [PAGES_REG_W-1:0] p,
                                input logic [THR_REG_W-1:0] t,
                                input bit align);
    bit widen_risk;
    drain();
    widen_risk = 1'b0;
    if (row_ctr != 0)
      for (int i = 0; i < active_cols(c); i++)
        if (!column_seen[i]) widen_risk = 1'b1;
    if (align || widen_risk) begin
      push_random(pixels_left_in_page());
      drain();
    end
    write_reg(CFG_COLUMN_COUNT, CFG_DATA_W'(c));
    write_reg(CFG_PAGE_COUNT, CFG_DATA_W'(p));
    write_reg(CFG_THRESHOLD, CFG_DATA_W'(t));
  endtask

  initial begin
    int unsigned random_pixels;
    int unsigned pick;
    logic [COLS_REG_W-1:0]  c;
    logic [PAGES_REG_W-1:0] p;
    logic [THR_REG_W-1:0]   t;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // zero column and page counts act as one: a single column frame of 8 rows,
    // pixel extremes against a zero threshold
    program_region(8'd0, 4'd0, 8'd0, 1'b0);
    pixel_q = '{8'd0, 8'd1, 8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd1};
    // threshold at its top: nothing can light
    program_region(8'd1, 4'd1, 8'd255, 1'b0);
    repeat (8) pixel_q.push_back(8'd255);
    // strictly-greater edge: 254 stays dark, 255 lights
    program_region(8'd1, 4'd1, 8'd254, 1'b0);
    repeat (4) begin
      pixel_q.push_back(8'd254);
      pixel_q.push_back(8'd255);
    end

    // narrow region with lots of pixels queued, where the long hold-off lands
    random_pixels = 0;
    program_region(COLS_REG_W'($urandom_range(1, 8)), PAGES_REG_W'($urandom_range(1, 3)),
                   THR_REG_W'($urandom_range(255)), 1'b0);
    push_random(200);
    random_pixels += 200;

    // full width via a saturating column count at full rate: row 0 of every
    // column, then column 0 alone down to the seventh row, then full width again
    // so the eighth row finishes all columns and closes the frame
    program_region(8'd200, 4'd1, 8'd127, 1'b1);
    no_idle = 1'b1;
    push_random(MAX_COLUMNS);
    program_region(8'd1, 4'd1, 8'd127, 1'b0);
    push_random(ROWS_PER_PAGE - 2);
    program_region(8'd200, 4'd1, 8'd127, 1'b0);
    push_random(MAX_COLUMNS);
    random_pixels += 2 * MAX_COLUMNS + ROWS_PER_PAGE - 2;
    drain();
    no_idle = 1'b0;

    // saturating page count: two columns walked through all eight pages
    program_region(8'd2, 4'd15, THR_REG_W'($urandom_range(255)), 1'b1);
    push_random(140);
    random_pixels += 140;

    // random regions, mostly narrow; phases stop mid-frame so the counts change
    // under running counters
    while (random_pixels < 760) begin
      pick = $urandom_range(99);
      if (pick < 10)      c = '0;
      else if (pick < 15) c = COLS_REG_W'($urandom_range(129, 255));
      else if (pick < 25) c = COLS_REG_W'($urandom_range(9, 128));
      else                c = COLS_REG_W'($urandom_range(1, 8));
      pick = $urandom_range(99);
      if (pick < 10)      p = '0;
      else if (pick < 20) p = PAGES_REG_W'($urandom_range(9, 15));
      else                p = PAGES_REG_W'($urandom_range(1, 4));
      pick = $urandom_range(99);
      if (pick < 10)      t = '0;
      else if (pick < 20) t = '1;
      else                t = THR_REG_W'($urandom_range(255));
      program_region(c, p, t, 1'b0);
      pick = $urandom_range(20, 120);
      push_random(pick);
      random_pixels += pick;
    end

    drain();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
